FILE: rtl/vsf_pkg.sv
// Shared types and codes of the stack and frame engine.
`default_nettype none
package vsf_pkg;

	// operation codes
	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_CALL  = 3'd3,
		OP_RET   = 3'd4,
		OP_STORE = 3'd5,
		OP_LOAD  = 3'd6,
		OP_COPY  = 3'd7
	} op_t;

	// result status codes
	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_OVERFLOW  = 4'd1,
		ST_UNDERFLOW = 4'd2,
		ST_BAD_ID    = 4'd3,
		ST_DEPTH     = 4'd4,
		ST_LOCALS    = 4'd5,
		ST_ARGS      = 4'd6,
		ST_STORE     = 4'd7,
		ST_LOAD      = 4'd8,
		ST_COPY      = 4'd9,
		ST_NO_FRAME  = 4'd10
	} status_t;

	// outcome of the call admission checks
	typedef struct packed {
		logic    ok;
		status_t st;
	} call_chk_t;

	// one frame record
	typedef struct packed {
		logic [31:0] ra;
		logic [7:0]  nloc;
	} frame_ent_t;

endpackage
`default_nettype wire

FILE: rtl/vsf_ifs.sv
// Request and response channel interfaces of the stack and frame engine.
`default_nettype none
interface vsf_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [63:0] value;
	logic [15:0]        func_id;
	logic [7:0]         locals_needed;
	logic [7:0]         args_needed;
	logic [31:0]        entry_address;
	logic [31:0]        current_pc;
	logic [7:0]         local_index;
	logic [7:0]         dest_index;

	modport source (output valid, func, value, func_id, locals_needed, args_needed,
		entry_address, current_pc, local_index, dest_index, input ready);
	modport sink (input valid, func, value, func_id, locals_needed, args_needed,
		entry_address, current_pc, local_index, dest_index, output ready);
endinterface

interface vsf_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] result_value;
	logic [31:0]        next_pc;
	logic [3:0]         status;
	logic               running;
	logic               error_seen;

	modport source (output valid, result_value, next_pc, status, running, error_seen,
		input ready);
	modport sink (input valid, result_value, next_pc, status, running, error_seen,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/vsf_call_check.sv
// Admission checks for a call: function id, frame depth, locals and arguments.
`default_nettype none
module vsf_call_check import vsf_pkg::*; #(
	parameter int CALL_DEPTH       = 64,
	parameter int LOCALS_PER_FRAME = 16,
	parameter int ARG_LIMIT        = 8,
	parameter int FCW              = 7
) (
	input  wire logic [15:0]    func_id,
	input  wire logic [15:0]    fn_limit,
	input  wire logic [FCW-1:0] frame_cnt,
	input  wire logic [7:0]     locals_needed,
	input  wire logic [7:0]     args_needed,
	output call_chk_t           chk
);

	// take the first failing check in priority order
	always_comb begin
		chk.ok = 1'b0;
		chk.st = ST_OK;
		if (func_id >= fn_limit) begin
			chk.st = ST_BAD_ID;
		end else if (frame_cnt >= FCW'(CALL_DEPTH)) begin
			chk.st = ST_DEPTH;
		end else if (locals_needed > 8'(LOCALS_PER_FRAME)) begin
			chk.st = ST_LOCALS;
		end else if (args_needed > 8'(ARG_LIMIT) || args_needed > locals_needed) begin
			chk.st = ST_ARGS;
		end else begin
			chk.ok = 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/vm_stack_and_frame_engine.sv
// Top level of the operand stack and call-frame engine.
// One word in, one word out per operation, one operation in flight at a time. Push, pop, peek,
// return and store run through accept, memory read, execute and deliver; load and copy add a
// second read of the local store. A good call, after execute, moves each argument with one
// operand-stack read and one local-store write, clears each remaining local one write a cycle
// on the single local-store port, then closes the argument loop and writes the frame record.
// A new word is taken while the last result still waits.
// Operand stack, frame records and locals sit in three single-port synchronous memories.
`default_nettype none
module vm_stack_and_frame_engine import vsf_pkg::*; #(
	parameter int OPERAND_DEPTH    = 256,
	parameter int CALL_DEPTH       = 64,
	parameter int LOCALS_PER_FRAME = 16,
	parameter int ARG_LIMIT        = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic [15:0] cfg_wdata,
	vsf_req_if.sink    req,
	vsf_rsp_if.source  rsp
);

	localparam int OCW = $clog2(OPERAND_DEPTH + 1);
	localparam int OIW = $clog2(OPERAND_DEPTH);
	localparam int FCW = $clog2(CALL_DEPTH + 1);
	localparam int FIW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
	localparam int SLOTS = CALL_DEPTH * LOCALS_PER_FRAME;
	localparam int LAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_RD     = 8'b0000_0010,
		S_EXEC   = 8'b0000_0100,
		S_LOC_RD = 8'b0000_1000,
		S_ARG_RD = 8'b0001_0000,
		S_ARG_WR = 8'b0010_0000,
		S_CLR    = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q;

	// latched operation
	op_t          op_q;
	logic [63:0]  val_q;
	logic [15:0]  fid_q;
	logic [7:0]   nloc_q, nargs_q, li_q, di_q;
	logic [31:0]  entry_q;

	// architectural state
	logic [OCW-1:0] cnt_q;
	logic [FCW-1:0] fc_q;
	logic [15:0]    fnc_q;
	logic           run_q, err_q;

	// working registers
	status_t      st_q;
	logic [63:0]  res_q;
	logic [31:0]  npc_q;
	logic         drop_q;
	logic [7:0]   k_q;
	logic         have_q;

	// output register
	logic         ovalid_q;
	logic [63:0]  ores_q;
	logic [31:0]  onpc_q;
	status_t      ost_q;
	logic         orun_q, oerr_q;

	// memories
	logic [63:0] stk_mem [OPERAND_DEPTH];
	frame_ent_t  frm_mem [CALL_DEPTH];
	logic [63:0] loc_mem [SLOTS];

	logic           stk_we, stk_re;
	logic [OIW-1:0] stk_wa, stk_ra;
	logic [63:0]    stk_rd_q;
	logic           frm_we, frm_re;
	logic [FIW-1:0] frm_wa, frm_ra;
	frame_ent_t     frm_wd, frm_rd_q;
	logic           loc_we, loc_re;
	logic [LAW-1:0] loc_wa, loc_ra;
	logic [63:0]    loc_wd, loc_rd_q;

	logic [OCW-1:0] cnt_m1;
	logic [FCW-1:0] fc_m1;
	logic [LAW-1:0] base_top, base_new, la_li, la_di;
	logic           full, fok, li_bad, di_bad;
	call_chk_t      chk;

	assign cnt_m1   = cnt_q - 1'b1;
	assign fc_m1    = fc_q - 1'b1;
	assign base_top = LAW'(fc_m1) * LAW'(LOCALS_PER_FRAME);
	assign base_new = LAW'(fc_q) * LAW'(LOCALS_PER_FRAME);
	assign la_li    = base_top + LAW'(li_q);
	assign la_di    = base_top + LAW'(di_q);
	assign full     = (cnt_q == OCW'(OPERAND_DEPTH));
	assign fok      = (fc_q != '0);
	assign li_bad   = (li_q >= frm_rd_q.nloc);
	assign di_bad   = (di_q >= frm_rd_q.nloc);

	vsf_call_check #(
		.CALL_DEPTH(CALL_DEPTH),
		.LOCALS_PER_FRAME(LOCALS_PER_FRAME),
		.ARG_LIMIT(ARG_LIMIT),
		.FCW(FCW)
	) u_check (
		.func_id(fid_q),
		.fn_limit(fnc_q),
		.frame_cnt(fc_q),
		.locals_needed(nloc_q),
		.args_needed(nargs_q),
		.chk(chk)
	);

	// drive memory ports from the sequencer state
	always_comb begin
		stk_we = 1'b0;
		stk_re = 1'b0;
		stk_wa = cnt_q[OIW-1:0];
		stk_ra = cnt_m1[OIW-1:0];
		frm_we = 1'b0;
		frm_re = 1'b0;
		frm_wa = fc_q[FIW-1:0];
		frm_ra = fc_m1[FIW-1:0];
		frm_wd.ra   = npc_q;
		frm_wd.nloc = nloc_q;
		loc_we = 1'b0;
		loc_re = 1'b0;
		loc_wa = la_li;
		loc_ra = la_li;
		loc_wd = val_q;
		unique case (state_q)
			S_RD: begin
				stk_re = (op_q == OP_POP) || (op_q == OP_PEEK);
				frm_re = (op_q == OP_RET) || (op_q == OP_STORE) ||
					(op_q == OP_LOAD) || (op_q == OP_COPY);
			end
			S_EXEC: begin
				stk_we = (op_q == OP_PUSH) && !full;
				loc_we = (op_q == OP_STORE) && fok && !li_bad;
				loc_re = fok && (((op_q == OP_LOAD) && !li_bad) ||
					((op_q == OP_COPY) && !li_bad && !di_bad));
			end
			S_LOC_RD: begin
				loc_we = (op_q == OP_COPY);
				loc_wa = la_di;
				loc_wd = loc_rd_q;
			end
			S_ARG_RD: begin
				stk_re = (k_q != '0) && (cnt_q != '0);
			end
			S_ARG_WR: begin
				loc_we = 1'b1;
				loc_wa = base_new + LAW'(k_q - 8'd1);
				loc_wd = have_q ? stk_rd_q : 64'd0;
			end
			S_CLR: begin
				loc_we = (k_q < nloc_q);
				loc_wa = base_new + LAW'(k_q);
				loc_wd = 64'd0;
				frm_we = (k_q >= nloc_q);
			end
			default: begin
			end
		endcase
	end

	// operand stack memory
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= val_q;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
	end

	// frame record memory
	always_ff @(posedge clk) begin
		if (frm_we) begin
			frm_mem[frm_wa] <= frm_wd;
		end
		if (frm_re) begin
			frm_rd_q <= frm_mem[frm_ra];
		end
	end

	// local store memory
	always_ff @(posedge clk) begin
		if (loc_we) begin
			loc_mem[loc_wa] <= loc_wd;
		end
		if (loc_re) begin
			loc_rd_q <= loc_mem[loc_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			fc_q     <= '0;
			fnc_q    <= '0;
			run_q    <= 1'b1;
			err_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fnc_q <= cfg_wdata;
			end
			// drop the delivered word
			if (ovalid_q && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= op_t'(req.func);
						val_q   <= req.value;
						fid_q   <= req.func_id;
						nloc_q  <= req.locals_needed;
						nargs_q <= req.args_needed;
						entry_q <= req.entry_address;
						npc_q   <= req.current_pc;
						li_q    <= req.local_index;
						di_q    <= req.dest_index;
						res_q   <= 64'd0;
						st_q    <= ST_OK;
						drop_q  <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_FIN;
					case (op_q) inside
						OP_PUSH: begin
							if (full) begin
								st_q <= ST_OVERFLOW;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						OP_POP, OP_PEEK: begin
							if (cnt_q == '0) begin
								st_q <= ST_UNDERFLOW;
							end else begin
								res_q <= stk_rd_q;
								if (op_q == OP_POP) begin
									cnt_q <= cnt_m1;
								end
							end
						end
						OP_CALL: begin
							if (!chk.ok) begin
								st_q <= chk.st;
							end else begin
								k_q     <= nargs_q;
								state_q <= S_ARG_RD;
							end
						end
						default: begin
							if (!fok) begin
								st_q <= ST_NO_FRAME;
							end else begin
								case (op_q)
									OP_RET: begin
										npc_q  <= frm_rd_q.ra;
										fc_q   <= fc_m1;
										drop_q <= (fc_m1 == '0);
									end
									OP_STORE: begin
										if (li_bad) begin
											st_q <= ST_STORE;
										end
									end
									OP_LOAD: begin
										if (li_bad) begin
											st_q <= ST_LOAD;
										end else begin
											state_q <= S_LOC_RD;
										end
									end
									default: begin
										if (li_bad || di_bad) begin
											st_q <= ST_COPY;
										end else begin
											state_q <= S_LOC_RD;
										end
									end
								endcase
							end
						end
					endcase
				end
				S_LOC_RD: begin
					if (op_q == OP_LOAD) begin
						res_q <= loc_rd_q;
					end
					state_q <= S_FIN;
				end
				S_ARG_RD: begin
					// pop one argument, or note an underflow
					if (k_q == '0) begin
						k_q     <= nargs_q;
						state_q <= S_CLR;
					end else begin
						if (cnt_q != '0) begin
							cnt_q  <= cnt_m1;
							have_q <= 1'b1;
						end else begin
							have_q <= 1'b0;
							st_q   <= ST_UNDERFLOW;
						end
						state_q <= S_ARG_WR;
					end
				end
				S_ARG_WR: begin
					k_q     <= k_q - 8'd1;
					state_q <= S_ARG_RD;
				end
				S_CLR: begin
					// clear remaining locals, then push the frame record
					if (k_q >= nloc_q) begin
						fc_q    <= fc_q + 1'b1;
						npc_q   <= entry_q;
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + 8'd1;
					end
				end
				S_FIN: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						ores_q   <= (op_q == OP_CALL) ? 64'd0 : res_q;
						onpc_q   <= npc_q;
						ost_q    <= st_q;
						orun_q   <= run_q && (st_q == ST_OK) && !drop_q;
						oerr_q   <= err_q || (st_q != ST_OK);
						run_q    <= run_q && (st_q == ST_OK) && !drop_q;
						err_q    <= err_q || (st_q != ST_OK);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = ovalid_q;
	assign rsp.result_value = ores_q;
	assign rsp.next_pc      = onpc_q;
	assign rsp.status       = ost_q;
	assign rsp.running      = orun_q;
	assign rsp.error_seen   = oerr_q;

endmodule
`default_nettype wire

FILE: rtl/vsf_checker.sv
// Port-level checks of the stack and frame engine, bound to its top level.
`default_nettype none
module vsf_checker import vsf_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [3:0] rsp_status,
	input wire logic       rsp_running,
	input wire logic       rsp_error_seen
);

	// a failed word reports the error and a stop
	a_err_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_error_seen && !rsp_running)
		else $error("failed word without error flags");

	// status stays within the defined codes
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status <= ST_NO_FRAME))
		else $error("status code out of range");

	// one operation at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready held after an accepted word");

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped under stall");

endmodule

bind vm_stack_and_frame_engine vsf_checker u_vsf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_status(rsp.status),
	.rsp_running(rsp.running),
	.rsp_error_seen(rsp.error_seen)
);
`default_nettype wire

FILE: bench/vm_stack_and_frame_engine_chk.sv
// Checker for the stack and frame engine: predicts each result word and compares it.
`timescale 1ns / 1ps
`default_nettype none
module vm_stack_and_frame_engine_chk import vsf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	vsf_req_if               req,
	vsf_rsp_if               rsp,
	output int               fails,
	output int               pending
);

	localparam int OPD   = 256;
	localparam int CDEP  = 64;
	localparam int LPF   = 16;
	localparam int ALIM  = 8;

	typedef struct packed {
		logic [63:0] result_value;
		logic [31:0] next_pc;
		status_t     status;
		logic        running;
		logic        error_seen;
	} result_word_t;

	// predicted machine state
	logic [15:0] fn_count;
	logic [63:0] opstk [OPD];
	int          op_depth;
	logic [31:0] ret_addr [CDEP];
	int          frame_locals [CDEP];
	int          frame_depth;
	logic [63:0] local_slots [CDEP*LPF];
	logic        run_flag;
	logic        err_flag;

	result_word_t awaited_results[$];

	// execute one operation on the predicted state and return its result word
	function automatic result_word_t execute_op(
		op_t op, logic [63:0] val, logic [15:0] fid, logic [7:0] nloc, logic [7:0] nargs,
		logic [31:0] entry, logic [31:0] pc, logic [7:0] li, logic [7:0] di);
		result_word_t r;
		status_t      st;
		logic [63:0]  res;
		logic [63:0]  arg;
		logic [31:0]  npc;
		int           base;
		int           top;
		int           cnt;
		st  = ST_OK;
		res = '0;
		npc = pc;
		case (op)
			OP_PUSH: begin
				if (op_depth >= OPD) st = ST_OVERFLOW;
				else begin
					opstk[op_depth] = val;
					op_depth++;
				end
			end
			OP_POP: begin
				if (op_depth == 0) st = ST_UNDERFLOW;
				else begin
					op_depth--;
					res = opstk[op_depth];
				end
			end
			OP_PEEK: begin
				if (op_depth == 0) st = ST_UNDERFLOW;
				else res = opstk[op_depth-1];
			end
			OP_CALL: begin
				if (fid >= fn_count) st = ST_BAD_ID;
				else if (frame_depth >= CDEP) st = ST_DEPTH;
				else if (nloc > LPF) st = ST_LOCALS;
				else if (nargs > ALIM || nargs > nloc) st = ST_ARGS;
				else begin
					base = frame_depth * LPF;
					for (int i = 0; i < LPF; i++) local_slots[base+i] = '0;
					// last argument lands in the highest slot; missing ones read zero
					for (int i = 0; i < nargs; i++) begin
						if (op_depth == 0) begin
							arg = '0;
							st  = ST_UNDERFLOW;
						end else begin
							op_depth--;
							arg = opstk[op_depth];
						end
						local_slots[base + nargs - i - 1] = arg;
					end
					frame_locals[frame_depth] = nloc;
					ret_addr[frame_depth] = pc;
					frame_depth++;
					npc = entry;
				end
			end
			default: begin
				if (frame_depth == 0) st = ST_NO_FRAME;
				else begin
					top  = frame_depth - 1;
					cnt  = frame_locals[top];
					base = top * LPF;
					case (op)
						OP_RET: begin
							frame_depth = top;
							npc = ret_addr[top];
							if (frame_depth == 0) run_flag = 1'b0;
						end
						OP_STORE: begin
							if (li >= cnt) st = ST_STORE;
							else local_slots[base+li] = val;
						end
						OP_LOAD: begin
							if (li >= cnt) st = ST_LOAD;
							else res = local_slots[base+li];
						end
						default: begin
							if (li >= cnt || di >= cnt) st = ST_COPY;
							else local_slots[base+di] = local_slots[base+li];
						end
					endcase
				end
			end
		endcase
		if (st != ST_OK) begin
			err_flag = 1'b1;
			run_flag = 1'b0;
			res = '0;
		end
		if (op == OP_CALL) res = '0;
		r.result_value = res;
		r.next_pc      = npc;
		r.status       = st;
		r.running      = run_flag;
		r.error_seen   = err_flag;
		return r;
	endfunction

	assign pending = awaited_results.size();

	// track configuration, predict on accepted requests, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		int           nbad;
		nbad = 0;
		if (!arst_n) begin
			fn_count    <= '0;
			op_depth    = 0;
			frame_depth = 0;
			run_flag    = 1'b1;
			err_flag    = 1'b0;
			fails       <= 0;
			awaited_results.delete();
		end else begin
			if (cfg_we) fn_count <= cfg_wdata;
			if (req.valid && req.ready)
				awaited_results.push_back(execute_op(op_t'(req.func), req.value, req.func_id,
					req.locals_needed, req.args_needed, req.entry_address, req.current_pc,
					req.local_index, req.dest_index));
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result word with nothing awaited");
					nbad++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.result_value !== want.result_value) begin
						$error("result_value: expected %h, got %h", want.result_value,
							rsp.result_value);
						nbad++;
					end
					if (rsp.next_pc !== want.next_pc) begin
						$error("next_pc: expected %h, got %h", want.next_pc, rsp.next_pc);
						nbad++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						nbad++;
					end
					if (rsp.running !== want.running) begin
						$error("running: expected %b, got %b", want.running, rsp.running);
						nbad++;
					end
					if (rsp.error_seen !== want.error_seen) begin
						$error("error_seen: expected %b, got %b", want.error_seen,
							rsp.error_seen);
						nbad++;
					end
				end
			end
			// one update of the count per edge
			if (nbad != 0) fails <= fails + nbad;
		end
	end

endmodule
`default_nettype wire

FILE: bench/vm_stack_and_frame_engine_tb.sv
// Top of the stack and frame engine bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module vm_stack_and_frame_engine_tb;
	import vsf_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE      = 40;

	typedef struct {
		op_t         op;
		logic [63:0] val;
		logic [15:0] fid;
		logic [7:0]  nloc;
		logic [7:0]  nargs;
		logic [31:0] entry;
		logic [31:0] pc;
		logic [7:0]  li;
		logic [7:0]  di;
	} op_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          fails;
	int          pending;
	int          cycles;
	int          snd_idle_pct;
	int          rcv_idle_pct;
	logic [15:0] fn_count;

	vsf_req_if req ();
	vsf_rsp_if rsp ();

	vm_stack_and_frame_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	vm_stack_and_frame_engine_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// stall the result side at random
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// offer one word, idling cycle by cycle ahead of it at the sender's idle rate
	task automatic send_word(input op_word_t w);
		while ($urandom_range(99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.func          <= w.op;
		req.value         <= w.val;
		req.func_id       <= w.fid;
		req.locals_needed <= w.nloc;
		req.args_needed   <= w.nargs;
		req.entry_address <= w.entry;
		req.current_pc    <= w.pc;
		req.local_index   <= w.li;
		req.dest_index    <= w.di;
		req.valid         <= 1'b1;
		do @(posedge clk); while (!req.ready);
	endtask

	// hold until every result is in, then rewrite the function count
	task automatic write_fn_count(input logic [15:0] v);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		fn_count = v;
	endtask

	function automatic op_word_t mk(op_t op, logic [63:0] val = 0, logic [15:0] fid = 0,
		logic [7:0] nloc = 0, logic [7:0] nargs = 0, logic [7:0] li = 0, logic [7:0] di = 0);
		op_word_t w;
		w.op = op; w.val = val; w.fid = fid; w.nloc = nloc; w.nargs = nargs;
		w.entry = $urandom; w.pc = $urandom; w.li = li; w.di = di;
		return w;
	endfunction

	// random operation; bias steers toward stack fill (1) or deep calls (2)
	function automatic op_word_t rand_word(int bias);
		op_word_t w;
		int       r;
		r = $urandom_range(99);
		if (bias == 1) w.op = (r < 70) ? OP_PUSH : op_t'($urandom_range(7));
		else if (bias == 2) w.op = (r < 45) ? OP_CALL : (r < 60) ? OP_PUSH
			: op_t'($urandom_range(7));
		else w.op = (r < 25) ? OP_PUSH : (r < 40) ? OP_CALL : (r < 50) ? OP_RET
			: op_t'($urandom_range(7));
		w.val   = {$urandom, $urandom};
		w.fid   = ($urandom_range(9) == 0 || fn_count == 0) ? 16'($urandom)
			: 16'($urandom_range(fn_count - 1));
		w.nloc  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(16));
		w.nargs = ($urandom_range(9) == 0) ? 8'($urandom)
			: 8'($urandom_range((w.nloc < 8) ? w.nloc : 8));
		w.entry = $urandom;
		w.pc    = $urandom;
		w.li    = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
		w.di    = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
		return w;
	endfunction

	initial begin
		logic [15:0] cfg_plan [8];
		cycles            = 0;
		snd_idle_pct      = 26;
		rcv_idle_pct      = 84;
		fn_count          = '0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req.valid         = 1'b0;
		req.func          = OP_PUSH;
		req.value         = '0;
		req.func_id       = '0;
		req.locals_needed = '0;
		req.args_needed   = '0;
		req.entry_address = '0;
		req.current_pc    = '0;
		req.local_index   = '0;
		req.dest_index    = '0;
		rsp.ready         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no frame, stack extremes, each call fault but depth, underflowing call
		write_fn_count(16'hFFFF);
		send_word(mk(OP_RET));
		send_word(mk(OP_STORE, 64'h1));
		send_word(mk(OP_LOAD));
		send_word(mk(OP_COPY));
		send_word(mk(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF));
		send_word(mk(OP_PUSH, 64'h8000_0000_0000_0000));
		send_word(mk(OP_PEEK));
		send_word(mk(OP_POP));
		send_word(mk(OP_POP));
		send_word(mk(OP_POP));
		send_word(mk(OP_CALL, 0, 16'hFFFF, 4, 1));
		send_word(mk(OP_CALL, 0, 0, 17, 1));
		send_word(mk(OP_CALL, 0, 0, 16, 9));
		send_word(mk(OP_CALL, 0, 0, 2, 3));
		send_word(mk(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF));
		send_word(mk(OP_CALL, 0, 16'hFFFE, 4, 3));
		send_word(mk(OP_LOAD, 0, 0, 0, 0, 0));
		send_word(mk(OP_LOAD, 0, 0, 0, 0, 2));
		send_word(mk(OP_LOAD, 0, 0, 0, 0, 3));
		send_word(mk(OP_STORE, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 3));
		send_word(mk(OP_COPY, 0, 0, 0, 0, 3, 0));
		send_word(mk(OP_LOAD, 0, 0, 0, 0, 0));
		send_word(mk(OP_STORE, 0, 0, 0, 0, 8'hFF));
		send_word(mk(OP_COPY, 0, 0, 0, 0, 0, 8'hC8));
		send_word(mk(OP_RET));
		send_word(mk(OP_RET));

		// random phases across function counts, biases and idling modes
		cfg_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd5, 16'($urandom), 16'hFFFF, 16'd3, 16'hFFFF};
		for (int p = 0; p < 8; p++) begin
			write_fn_count(cfg_plan[p]);
			if (p < 3) begin
				snd_idle_pct = 26;
				rcv_idle_pct = 84;
			end else if (p < 6) begin
				snd_idle_pct = 84;
				rcv_idle_pct = 26;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			for (int n = 0; n < 250; n++)
				send_word(rand_word((p == 2 || p == 6) ? 1 : (p == 5 || p == 7) ? 2 : 0));
		end
		req.valid <= 1'b0;
		@(posedge clk);

		// drain, then settle
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/vsf_pkg.sv
rtl/vsf_ifs.sv
rtl/vsf_call_check.sv
rtl/vm_stack_and_frame_engine.sv
rtl/vsf_checker.sv
bench/vm_stack_and_frame_engine_chk.sv
bench/vm_stack_and_frame_engine_tb.sv
